/* hdl/gregorian_date_add_days_assert.svh */
// assertion macros for the gregorian date adder
// used by the top level, no other dependencies
`ifndef GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH

// same-cycle implication
`define GDAD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GDAD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/gdad_pkg.sv */
// shared widths, constants, types and month table for the date adder
// no dependencies
package gdad_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int ADD_W   = 15;
   localparam int REM_W   = 16;
   localparam int YCNT_W  = 15;

   localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR       = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN       = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP       = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV       = 4'd11;
   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;

   localparam logic [REM_W-1:0] YEAR_DAYS      = 16'd365;
   localparam logic [REM_W-1:0] LEAP_YEAR_DAYS = 16'd366;

   localparam logic [YEAR_W-1:0] STEP_1600 = 14'd1600;
   localparam logic [YEAR_W-1:0] STEP_400  = 14'd400;
   localparam logic [YEAR_W-1:0] STEP_100  = 14'd100;
   localparam logic [6:0]        CENT_LAST = 7'd99;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_DOY    = 5'b00100,
      ST_YEARS  = 5'b01000,
      ST_MONTHS = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic inc;
   } yr_ctl_type;

   typedef struct packed {
      logic busy;
      logic leap;
   } yr_sts_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

/* hdl/gdad_req_if.sv */
// request channel: start date and day count
// depends on gdad_pkg
interface gdad_req_if;
   logic                         valid;
   logic                         ready;
   logic [gdad_pkg::DAY_W-1:0]   start_day;
   logic [gdad_pkg::MONTH_W-1:0] start_month;
   logic [gdad_pkg::YEAR_W-1:0]  start_year;
   logic [gdad_pkg::ADD_W-1:0]   days_to_add;

   modport source (output valid, start_day, start_month, start_year, days_to_add,
                   input ready);
   modport sink (input valid, start_day, start_month, start_year, days_to_add,
                 output ready);
endinterface

/* hdl/gdad_rsp_if.sv */
// response channel: resulting date
// depends on gdad_pkg
interface gdad_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gdad_pkg::DAY_W-1:0]   result_day;
   logic [gdad_pkg::MONTH_W-1:0] result_month;
   logic [gdad_pkg::YEAR_W-1:0]  result_year;

   modport source (output valid, result_day, result_month, result_year, input ready);
   modport sink (input valid, result_day, result_month, result_year, output ready);
endinterface

/* hdl/gdad_year_ctr.sv */
// year counter with century tracking for the leap rule
// depends on gdad_pkg
module gdad_year_ctr (
   input  logic                          clock,
   input  logic                          reset,
   input  gdad_pkg::yr_ctl_type          ctl,
   input  logic [gdad_pkg::YEAR_W-1:0]   load_year,
   output gdad_pkg::yr_sts_type          sts,
   output logic [gdad_pkg::YCNT_W-1:0]   year
);

   logic [gdad_pkg::YCNT_W-1:0] year_ff, year_in;
   logic [gdad_pkg::YEAR_W-1:0] red_ff, red_in;
   logic [6:0]                  cent_ff, cent_in;
   logic [1:0]                  quad_ff, quad_in;
   logic                        busy_ff, busy_in;
   logic [gdad_pkg::YEAR_W-1:0] step;

   always_comb begin
      if (red_ff >= gdad_pkg::STEP_1600) begin
         step = gdad_pkg::STEP_1600;
      end else if (red_ff >= gdad_pkg::STEP_400) begin
         step = gdad_pkg::STEP_400;
      end else begin
         step = gdad_pkg::STEP_100;
      end
   end

   always_comb begin
      year_in = year_ff;
      red_in  = red_ff;
      cent_in = cent_ff;
      quad_in = quad_ff;
      busy_in = busy_ff;
      if (ctl.load) begin
         year_in = {1'b0, load_year};
         red_in  = load_year;
         quad_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // strip 1600, then 400, then 100 counting centuries
         if (red_ff >= gdad_pkg::STEP_100) begin
            red_in = red_ff - step;
            if (step == gdad_pkg::STEP_100) begin
               quad_in = quad_ff + 2'd1;
            end
         end else begin
            cent_in = red_ff[6:0];
            busy_in = 1'b0;
         end
      end else if (ctl.inc) begin
         year_in = year_ff + 15'd1;
         if (cent_ff == gdad_pkg::CENT_LAST) begin
            cent_in = 7'd0;
            quad_in = quad_ff + 2'd1;
         end else begin
            cent_in = cent_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      year_ff <= year_in;
      red_ff  <= red_in;
      cent_ff <= cent_in;
      quad_ff <= quad_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign year      = year_ff;
   assign sts.busy  = busy_ff;
   assign sts.leap  = ((cent_ff[1:0] == 2'd0) && (cent_ff != 7'd0)) ||
                      ((cent_ff == 7'd0) && (quad_ff == 2'd0));

endmodule

/* hdl/gregorian_date_add_days.sv */
// top level of the gregorian date adder: sequencer and shared add/subtract unit
// depends on gdad_pkg, gdad_req_if, gdad_rsp_if, gdad_year_ctr
// and gregorian_date_add_days_assert.svh
//
//  channel   dir  handshake      payload
//  req_bus   in   valid/ready    start_day, start_month, start_year, days_to_add
//  rsp_bus   out  valid/ready    result_day, result_month, result_year
//
// one item at a time; req_bus.ready is high only when idle
// per item: a load, then century reduction, day-of-year, whole years and months;
// the year and month walks go through the one add/subtract unit
// the result sits in an output register until taken; a full one holds the last month step
// synchronous reset returns to idle and empties the output register
`include "gregorian_date_add_days_assert.svh"

module gregorian_date_add_days (
   input logic     clock,
   input logic     reset,
   gdad_req_if.sink   req_bus,
   gdad_rsp_if.source rsp_bus
);

   gdad_pkg::state_type state_ff, state_in;

   logic [gdad_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [gdad_pkg::ADD_W-1:0]   add_ff, add_in;
   logic [gdad_pkg::MONTH_W-1:0] target_ff, target_in;
   logic [gdad_pkg::MONTH_W-1:0] mon_ff, mon_in;
   logic [gdad_pkg::DAY_W-1:0]   res_day_ff, res_day_in;
   logic [gdad_pkg::MONTH_W-1:0] res_month_ff, res_month_in;
   logic [gdad_pkg::YEAR_W-1:0]  res_year_ff, res_year_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   gdad_pkg::yr_ctl_type        yr_ctl;
   gdad_pkg::yr_sts_type        yr_sts;
   logic [gdad_pkg::YCNT_W-1:0] year;

   logic [gdad_pkg::REM_W-1:0] opnd;
   logic                       do_sub;
   logic [gdad_pkg::REM_W:0]   alu;
   logic                       over;
   logic                       req_beat;
   logic [gdad_pkg::DAY_W-1:0] cur_len;

   gdad_year_ctr u_year (
      .clock     (clock),
      .reset     (reset),
      .ctl       (yr_ctl),
      .load_year (req_bus.start_year),
      .sts       (yr_sts),
      .year      (year)
   );

   assign req_beat = req_bus.valid && req_bus.ready;
   assign cur_len  = gdad_pkg::month_len(mon_ff, yr_sts.leap);

   // shared add/subtract unit
   always_comb begin
      do_sub = 1'b1;
      opnd   = {{(gdad_pkg::REM_W-gdad_pkg::DAY_W){1'b0}}, cur_len};
      case (state_ff)
         gdad_pkg::ST_DOY: begin
            do_sub = 1'b0;
            if (mon_ff == target_ff) begin
               opnd = {{(gdad_pkg::REM_W-gdad_pkg::ADD_W){1'b0}}, add_ff};
            end
         end
         gdad_pkg::ST_YEARS: begin
            opnd = yr_sts.leap ? gdad_pkg::LEAP_YEAR_DAYS : gdad_pkg::YEAR_DAYS;
         end
         default: begin
            opnd = {{(gdad_pkg::REM_W-gdad_pkg::DAY_W){1'b0}}, cur_len};
         end
      endcase
      if (do_sub) begin
         alu = {1'b0, rem_ff} - {1'b0, opnd};
      end else begin
         alu = {1'b0, rem_ff} + {1'b0, opnd};
      end
      over = !alu[gdad_pkg::REM_W] && (alu[gdad_pkg::REM_W-1:0] != '0);
   end

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      add_in       = add_ff;
      target_in    = target_ff;
      mon_in       = mon_ff;
      res_day_in   = res_day_ff;
      res_month_in = res_month_ff;
      res_year_in  = res_year_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      yr_ctl       = '0;
      case (state_ff)
         gdad_pkg::ST_IDLE: begin
            if (req_beat) begin
               yr_ctl.load = 1'b1;
               add_in      = req_bus.days_to_add;
               mon_in      = gdad_pkg::MONTH_JAN;
               if (req_bus.start_month == '0) begin
                  target_in = gdad_pkg::MONTH_JAN;
               end else if (req_bus.start_month > gdad_pkg::MONTHS_PER_YEAR) begin
                  target_in = gdad_pkg::MONTHS_PER_YEAR;
               end else begin
                  target_in = req_bus.start_month;
               end
               if (req_bus.start_day == '0) begin
                  rem_in = 16'd1;
               end else begin
                  rem_in = {{(gdad_pkg::REM_W-gdad_pkg::DAY_W){1'b0}}, req_bus.start_day};
               end
               state_in = gdad_pkg::ST_REDUCE;
            end
         end
         gdad_pkg::ST_REDUCE: begin
            if (!yr_sts.busy) begin
               state_in = gdad_pkg::ST_DOY;
            end
         end
         gdad_pkg::ST_DOY: begin
            rem_in = alu[gdad_pkg::REM_W-1:0];
            if (mon_ff == target_ff) begin
               mon_in   = gdad_pkg::MONTH_JAN;
               state_in = gdad_pkg::ST_YEARS;
            end else begin
               mon_in = mon_ff + 4'd1;
            end
         end
         gdad_pkg::ST_YEARS: begin
            if (over) begin
               rem_in     = alu[gdad_pkg::REM_W-1:0];
               yr_ctl.inc = 1'b1;
            end else begin
               state_in = gdad_pkg::ST_MONTHS;
            end
         end
         gdad_pkg::ST_MONTHS: begin
            if (over) begin
               rem_in = alu[gdad_pkg::REM_W-1:0];
               if (mon_ff == gdad_pkg::MONTHS_PER_YEAR) begin
                  mon_in     = gdad_pkg::MONTH_JAN;
                  yr_ctl.inc = 1'b1;
               end else begin
                  mon_in = mon_ff + 4'd1;
               end
            end else if (!rsp_valid_ff || rsp_bus.ready) begin
               res_day_in   = rem_ff[gdad_pkg::DAY_W-1:0];
               res_month_in = mon_ff;
               res_year_in  = year[gdad_pkg::YEAR_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = gdad_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gdad_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      add_ff       <= add_in;
      target_ff    <= target_in;
      mon_ff       <= mon_in;
      res_day_ff   <= res_day_in;
      res_month_ff <= res_month_in;
      res_year_ff  <= res_year_in;
      if (reset) begin
         state_ff     <= gdad_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_bus.ready        = (state_ff == gdad_pkg::ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_day   = res_day_ff;
   assign rsp_bus.result_month = res_month_ff;
   assign rsp_bus.result_year  = res_year_ff;

   `GDAD_ASSERT_NOW(a_rsp_month_range, rsp_bus.valid, (res_month_ff != 4'd0) && (res_month_ff <= gdad_pkg::MONTHS_PER_YEAR), "result month out of range")
   `GDAD_ASSERT_NOW(a_rsp_day_nonzero, rsp_bus.valid, res_day_ff != 5'd0, "result day is zero")
   `GDAD_ASSERT_NEXT(a_busy_after_beat, req_beat, !req_bus.ready, "ready right after a request beat")
   `GDAD_ASSERT_NOW(a_walk_month_range, state_ff == gdad_pkg::ST_MONTHS, (mon_ff != 4'd0) && (mon_ff <= gdad_pkg::MONTHS_PER_YEAR), "month walk out of range")
   `GDAD_ASSERT_NEXT(a_rsp_held, rsp_bus.valid && !rsp_bus.ready, rsp_bus.valid && $stable({res_day_ff, res_month_ff, res_year_ff}), "result beat dropped or changed while stalled")

endmodule

/* tb/gregorian_date_add_days_tb.sv */
`timescale 1ns / 100ps
// testbench for gregorian_date_add_days: directed and random dates, checked by a scoreboard
// depends on gdad_pkg, gdad_req_if, gdad_rsp_if and the gregorian_date_add_days rtl
module gregorian_date_add_days_tb;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 100;

   typedef struct packed {
      logic [gdad_pkg::DAY_W-1:0]   day;
      logic [gdad_pkg::MONTH_W-1:0] month;
      logic [gdad_pkg::YEAR_W-1:0]  year;
      logic [gdad_pkg::ADD_W-1:0]   add;
   } date_req_type;

   typedef struct packed {
      logic [gdad_pkg::DAY_W-1:0]   day;
      logic [gdad_pkg::MONTH_W-1:0] month;
      logic [gdad_pkg::YEAR_W-1:0]  year;
   } date_rsp_type;

   class date_checker;
      date_rsp_type pending_dates[$];
      int           errors;

      function new();
         errors = 0;
      endfunction

      static function bit leap_year(int unsigned y);
         return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
      endfunction

      static function int unsigned month_days(int unsigned y, int unsigned m);
         int unsigned len;
         if (m == gdad_pkg::MONTH_FEB) begin
            len = leap_year(y) ? 29 : 28;
         end else if (m == gdad_pkg::MONTH_APR || m == gdad_pkg::MONTH_JUN ||
                      m == gdad_pkg::MONTH_SEP || m == gdad_pkg::MONTH_NOV) begin
            len = 30;
         end else begin
            len = 31;
         end
         return len;
      endfunction

      static function int unsigned year_days(int unsigned y);
         return leap_year(y) ? 366 : 365;
      endfunction

      function void report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endfunction

      // note an accepted request beat and queue the date it should produce
      function void note(date_req_type r);
         int unsigned  day, month, year, left, m;
         date_rsp_type later;
         day   = r.day;
         month = r.month;
         year  = r.year;
         if (month == 0) month = 1;
         if (month > gdad_pkg::MONTHS_PER_YEAR) month = gdad_pkg::MONTHS_PER_YEAR;
         if (day == 0) day = 1;
         left = day;
         for (m = 1; m < month; m++) left += month_days(year, m);
         left += r.add;
         while (left > year_days(year)) begin
            left -= year_days(year);
            year++;
         end
         month = 1;
         while (left > month_days(year, month)) begin
            left -= month_days(year, month);
            month++;
            if (month > gdad_pkg::MONTHS_PER_YEAR) begin
               month = 1;
               year++;
            end
         end
         later.day   = left[gdad_pkg::DAY_W-1:0];
         later.month = month[gdad_pkg::MONTH_W-1:0];
         later.year  = year[gdad_pkg::YEAR_W-1:0];
         pending_dates.push_back(later);
      endfunction

      function void check(date_rsp_type got);
         date_rsp_type want;
         if (pending_dates.size() == 0) begin
            report($sformatf("unexpected result %0d-%0d-%0d", got.year, got.month, got.day));
            return;
         end
         want = pending_dates.pop_front();
         if (got.day !== want.day)
            report($sformatf("result_day %0d, want %0d", got.day, want.day));
         if (got.month !== want.month)
            report($sformatf("result_month %0d, want %0d", got.month, want.month));
         if (got.year !== want.year)
            report($sformatf("result_year %0d, want %0d", got.year, want.year));
      endfunction

      function int outstanding();
         return pending_dates.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   stall_pct;
   int   cycles;

   date_checker book = new();

   gdad_req_if req ();
   gdad_rsp_if rsp ();

   gregorian_date_add_days i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: ready changes on the falling edge, beats taken on the rising edge
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         book.check('{rsp.result_day, rsp.result_month, rsp.result_year});
   end

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_date(input logic [gdad_pkg::DAY_W-1:0] d,
                            input logic [gdad_pkg::MONTH_W-1:0] m,
                            input logic [gdad_pkg::YEAR_W-1:0] y,
                            input logic [gdad_pkg::ADD_W-1:0] a);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid       <= 1'b1;
      req.start_day   <= d;
      req.start_month <= m;
      req.start_year  <= y;
      req.days_to_add <= a;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      book.note('{d, m, y, a});
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      do @(negedge clock); while (book.outstanding() != 0);
   endtask

   initial begin
      int                           phase, k, mc;
      logic [gdad_pkg::DAY_W-1:0]   d;
      logic [gdad_pkg::MONTH_W-1:0] m;
      logic [gdad_pkg::YEAR_W-1:0]  y;
      logic [gdad_pkg::ADD_W-1:0]   a;

      cycles          = 0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      reset           = 1'b1;
      req.valid       = 1'b0;
      req.start_day   = '0;
      req.start_month = '0;
      req.start_year  = '0;
      req.days_to_add = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // field extremes and corner dates
      send_date(5'd1, 4'd1, 14'd1, 15'd0);
      send_date(5'd31, 4'd12, 14'd9999, 15'd32767);
      send_date(5'd0, 4'd0, 14'd0, 15'd0);
      send_date(5'd31, 4'd15, 14'd16383, 15'd32767);
      send_date(5'd31, 4'd13, 14'd2023, 15'd1);
      send_date(5'd15, 4'd14, 14'd2023, 15'd0);
      send_date(5'd31, 4'd2, 14'd2023, 15'd0);
      send_date(5'd31, 4'd2, 14'd2024, 15'd0);
      send_date(5'd28, 4'd2, 14'd2024, 15'd1);
      send_date(5'd28, 4'd2, 14'd1900, 15'd1);
      send_date(5'd28, 4'd2, 14'd2000, 15'd1);
      send_date(5'd31, 4'd12, 14'd1999, 15'd1);
      send_date(5'd1, 4'd3, 14'd0, 15'd365);
      send_date(5'd21, 4'd10, 14'd10922, 15'd21845);
      send_date(5'd10, 4'd5, 14'd5461, 15'd10922);
      send_date(5'd30, 4'd6, 14'd2023, 15'd31);
      send_date(5'd1, 4'd1, 14'd2000, 15'd366);
      send_date(5'd1, 4'd1, 14'd2001, 15'd365);
      send_date(5'd29, 4'd2, 14'd2400, 15'd1461);
      send_date(5'd31, 4'd1, 14'd2023, 15'd28);
      send_date(5'd31, 4'd12, 14'd16383, 15'd1);
      drain();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 45; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 45; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
         endcase
         for (k = 0; k < RANDOM_ITEMS; k++) begin
            y = 14'(($urandom_range(0, 99) < 15) ? $urandom_range(0, 16383)
                                                 : $urandom_range(1, 9999));
            m = 4'(($urandom_range(0, 99) < 10) ? $urandom_range(0, 15)
                                                : $urandom_range(1, 12));
            mc = (m == 0) ? 1 : ((m > gdad_pkg::MONTHS_PER_YEAR) ?
                                 int'(gdad_pkg::MONTHS_PER_YEAR) : int'(m));
            if ($urandom_range(0, 99) < 10)
               d = 5'($urandom_range(0, 31));
            else
               d = 5'($urandom_range(1, date_checker::month_days(y, mc)));
            case ($urandom_range(0, 3))
               0: a = 15'($urandom_range(0, 31));
               1: a = 15'($urandom_range(0, 400));
               2: a = 15'($urandom_range(0, 3000));
               default: a = 15'($urandom_range(0, 32767));
            endcase
            send_date(d, m, y, a);
         end
         // hold off the sender until the block has emptied
         drain();
      end

      repeat (150) @(negedge clock);
      if (book.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
